[rtl/mccs_pkg.sv]
package mccs_pkg;

  localparam int unsigned NumCtrl = 8;
  localparam int unsigned SlotW   = 3;

  localparam logic [7:0] PktStatus = 8'd9;
  localparam logic [16:0] DutyOne  = 17'd100000;
  localparam logic [19:0] CurrentLimitRst = 20'd30000;
  localparam logic [16:0] DutyLimitRst    = 17'd100000;

  typedef enum logic [2:0] {
    FUNC_RX        = 3'd0,
    FUNC_CURRENT   = 3'd1,
    FUNC_CUR_PCT   = 3'd2,
    FUNC_BRAKE     = 3'd3,
    FUNC_DUTY      = 3'd4,
    FUNC_DUTY_PCT  = 3'd5,
    FUNC_RPM       = 3'd6,
    FUNC_READ      = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    PKT_DUTY    = 2'd0,
    PKT_CURRENT = 2'd1,
    PKT_BRAKE   = 2'd2,
    PKT_RPM     = 2'd3
  } pkt_e;

  typedef enum logic {
    REG_CURRENT_LIMIT = 1'b0,
    REG_DUTY_LIMIT    = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_RX    = 3'd0,
    OP_READ  = 3'd1,
    OP_CLAMP = 3'd2,
    OP_FRAC  = 3'd3,
    OP_PASS  = 3'd4
  } op_e;

  // classified item as handed from front to back
  typedef struct packed {
    op_e                op;
    logic               ok;
    logic [SlotW-1:0]   slot;
    logic [7:0]         target;
    pkt_e               pkt;
    logic signed [31:0] value;
    logic signed [17:0] frac;
    logic [19:0]        lim;
    logic [63:0]        payload;
  } entry_t;

endpackage

[rtl/mccs_front.sv]
module mccs_front (
  input  logic                  start_i,
  input  logic                  full_i,
  input  logic [2:0]            func_i,
  input  logic [28:0]           rx_frame_id_i,
  input  logic [63:0]           rx_payload_i,
  input  logic [7:0]            target_i,
  input  logic signed [31:0]    command_value_i,
  input  logic signed [17:0]    fraction_i,
  input  logic [19:0]           current_limit_i,
  input  logic [16:0]           duty_limit_i,
  output logic                  push_o,
  output mccs_pkg::entry_t      entry_o
);

  logic [7:0]  code_w;
  logic [7:0]  cid_w;
  logic [7:0]  id_w;
  logic [19:0] dlim_w;
  logic        id_ok_w;

  assign code_w = rx_frame_id_i[15:8];
  assign cid_w  = rx_frame_id_i[7:0];
  assign push_o = start_i && !full_i;

  always_comb begin
    dlim_w = (duty_limit_i > mccs_pkg::DutyOne) ? {3'b0, mccs_pkg::DutyOne}
                                               : {3'b0, duty_limit_i};
  end

  assign id_w    = (mccs_pkg::func_e'(func_i) == mccs_pkg::FUNC_RX) ? cid_w : target_i;
  assign id_ok_w = (id_w >= 8'd1) && (id_w <= 8'(mccs_pkg::NumCtrl));

  always_comb begin
    entry_o.ok      = id_ok_w;
    entry_o.slot    = mccs_pkg::SlotW'(id_w - 8'd1);
    entry_o.target  = target_i;
    entry_o.value   = command_value_i;
    entry_o.frac    = fraction_i;
    entry_o.payload = rx_payload_i;
    entry_o.lim     = current_limit_i;
    entry_o.pkt     = mccs_pkg::PKT_RPM;
    entry_o.op      = mccs_pkg::OP_PASS;
    unique case (mccs_pkg::func_e'(func_i))
      mccs_pkg::FUNC_RX: begin
        entry_o.op = mccs_pkg::OP_RX;
        entry_o.ok = id_ok_w && (code_w == mccs_pkg::PktStatus);
      end
      mccs_pkg::FUNC_CURRENT: begin
        entry_o.op  = mccs_pkg::OP_CLAMP;
        entry_o.pkt = mccs_pkg::PKT_CURRENT;
      end
      mccs_pkg::FUNC_CUR_PCT: begin
        entry_o.op  = mccs_pkg::OP_FRAC;
        entry_o.pkt = mccs_pkg::PKT_CURRENT;
      end
      mccs_pkg::FUNC_BRAKE: begin
        entry_o.op  = mccs_pkg::OP_CLAMP;
        entry_o.pkt = mccs_pkg::PKT_BRAKE;
      end
      mccs_pkg::FUNC_DUTY: begin
        entry_o.op  = mccs_pkg::OP_CLAMP;
        entry_o.pkt = mccs_pkg::PKT_DUTY;
        entry_o.lim = dlim_w;
      end
      mccs_pkg::FUNC_DUTY_PCT: begin
        entry_o.op  = mccs_pkg::OP_FRAC;
        entry_o.pkt = mccs_pkg::PKT_DUTY;
        entry_o.lim = dlim_w;
      end
      mccs_pkg::FUNC_RPM: begin
        entry_o.op  = mccs_pkg::OP_PASS;
        entry_o.pkt = mccs_pkg::PKT_RPM;
      end
      mccs_pkg::FUNC_READ: begin
        entry_o.op = mccs_pkg::OP_READ;
      end
      default: begin
        entry_o.op = mccs_pkg::OP_PASS;
      end
    endcase
  end

endmodule

[rtl/mccs_fifo.sv]
module mccs_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mccs_pkg::entry_t data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output mccs_pkg::entry_t data_o
);

  mccs_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/mccs_back.sv]
module mccs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  mccs_pkg::entry_t    entry_i,
  output logic                pop_o,
  output logic                done_o,
  output logic                accepted_o,
  output logic [2:0]          slot_o,
  output logic [9:0]          tx_id_o,
  output logic [3:0]          tx_len_o,
  output logic [31:0]         tx_payload_o,
  output logic signed [31:0]  rpm_o,
  output logic signed [15:0]  current_tenths_o,
  output logic signed [15:0]  duty_thousandths_o
);

  // stage A: fraction times limit
  logic               a_vld_q;
  mccs_pkg::entry_t   a_ent_q;
  logic signed [38:0] a_prod_q;
  logic signed [38:0] prod_w;

  logic [63:0] table_q [mccs_pkg::NumCtrl];

  logic signed [38:0] rnd_w;
  logic signed [38:0] fq_w;
  logic signed [39:0] v_w;
  logic signed [39:0] lim_w;
  logic signed [39:0] clamped_w;
  logic [63:0]        status_w;

  logic        accepted_d;
  logic [2:0]  slot_d;
  logic [9:0]  tx_id_d;
  logic [3:0]  tx_len_d;
  logic [31:0] tx_payload_d;
  logic [63:0] stat_d;

  assign pop_o  = valid_i;
  assign prod_w = entry_i.frac * $signed({1'b0, entry_i.lim});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      a_ent_q  <= entry_i;
      a_prod_q <= prod_w;
    end
  end

  // truncate toward zero: bias negatives before the shift
  always_comb begin
    rnd_w = a_prod_q + (a_prod_q[38] ? 39'sd65535 : 39'sd0);
    fq_w  = rnd_w >>> 16;
    lim_w = $signed({20'b0, a_ent_q.lim});
    if (a_ent_q.op == mccs_pkg::OP_FRAC) begin
      v_w = {fq_w[38], fq_w};
    end else begin
      v_w = {{8{a_ent_q.value[31]}}, a_ent_q.value};
    end
    priority if (a_ent_q.op == mccs_pkg::OP_PASS) begin
      clamped_w = v_w;
    end else if (v_w > lim_w) begin
      clamped_w = lim_w;
    end else if (v_w < -lim_w) begin
      clamped_w = -lim_w;
    end else begin
      clamped_w = v_w;
    end
  end

  assign status_w = (a_ent_q.op == mccs_pkg::OP_RX) ? a_ent_q.payload
                                                   : table_q[a_ent_q.slot];

  always_comb begin
    accepted_d   = a_ent_q.ok;
    slot_d       = 3'd0;
    tx_id_d      = 10'd0;
    tx_len_d     = 4'd0;
    tx_payload_d = 32'd0;
    stat_d       = 64'd0;
    if (a_ent_q.ok) begin
      slot_d = a_ent_q.slot;
      unique case (a_ent_q.op)
        mccs_pkg::OP_RX, mccs_pkg::OP_READ: begin
          stat_d = status_w;
        end
        mccs_pkg::OP_CLAMP, mccs_pkg::OP_FRAC, mccs_pkg::OP_PASS: begin
          tx_id_d      = {a_ent_q.pkt, a_ent_q.target};
          tx_len_d     = 4'd4;
          tx_payload_d = clamped_w[31:0];
        end
        default: begin
          stat_d = 64'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mccs_pkg::NumCtrl; i++) begin
        table_q[i] <= 64'd0;
      end
    end else if (a_vld_q && a_ent_q.ok && (a_ent_q.op == mccs_pkg::OP_RX)) begin
      table_q[a_ent_q.slot] <= a_ent_q.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      accepted_o         <= accepted_d;
      slot_o             <= slot_d;
      tx_id_o            <= tx_id_d;
      tx_len_o           <= tx_len_d;
      tx_payload_o       <= tx_payload_d;
      rpm_o              <= $signed(stat_d[63:32]);
      current_tenths_o   <= $signed(stat_d[31:16]);
      duty_thousandths_o <= $signed(stat_d[15:0]);
    end
  end

endmodule

[rtl/motor_ctrl_can_command_status_unit.sv]
// Motor-controller CAN command/status codec. An item is taken when start_i is
// high and busy_o is low; its result appears with done_o after the pipeline
// (classify into a two-entry queue, multiply stage, clamp/table stage),
// and a new item may be started every cycle. The result side has no stall, so
// the queue drains one item per cycle and busy_o only rises if it fills.
// The eight-slot status table is cleared by reset. Limits must be written via
// cfg_we_i/cfg_idx_i/cfg_wdata_i only while no item is in flight (unenforced).
module motor_ctrl_can_command_status_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         func_i,
  input  logic [28:0]        rx_frame_id_i,
  input  logic [63:0]        rx_payload_i,
  input  logic [7:0]         target_i,
  input  logic signed [31:0] command_value_i,
  input  logic signed [17:0] fraction_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [19:0]        cfg_wdata_i,
  output logic               done_o,
  output logic               accepted_o,
  output logic [2:0]         slot_o,
  output logic [9:0]         tx_id_o,
  output logic [3:0]         tx_len_o,
  output logic [31:0]        tx_payload_o,
  output logic signed [31:0] rpm_o,
  output logic signed [15:0] current_tenths_o,
  output logic signed [15:0] duty_thousandths_o
);

  logic [19:0] current_limit_q;
  logic [16:0] duty_limit_q;

  logic             push_w, full_w, pop_w, fifo_vld_w;
  mccs_pkg::entry_t front_ent_w, fifo_ent_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_limit_q <= mccs_pkg::CurrentLimitRst;
      duty_limit_q    <= mccs_pkg::DutyLimitRst;
    end else if (cfg_we_i) begin
      unique case (mccs_pkg::reg_idx_e'(cfg_idx_i))
        mccs_pkg::REG_CURRENT_LIMIT: current_limit_q <= cfg_wdata_i;
        mccs_pkg::REG_DUTY_LIMIT:    duty_limit_q    <= cfg_wdata_i[16:0];
        default:                     current_limit_q <= current_limit_q;
      endcase
    end
  end

  assign busy_o = full_w;

  mccs_front u_front (
    .start_i         (start_i),
    .full_i          (full_w),
    .func_i          (func_i),
    .rx_frame_id_i   (rx_frame_id_i),
    .rx_payload_i    (rx_payload_i),
    .target_i        (target_i),
    .command_value_i (command_value_i),
    .fraction_i      (fraction_i),
    .current_limit_i (current_limit_q),
    .duty_limit_i    (duty_limit_q),
    .push_o          (push_w),
    .entry_o         (front_ent_w)
  );

  mccs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .data_i  (front_ent_w),
    .pop_i   (pop_w),
    .full_o  (full_w),
    .valid_o (fifo_vld_w),
    .data_o  (fifo_ent_w)
  );

  mccs_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (fifo_vld_w),
    .entry_i            (fifo_ent_w),
    .pop_o              (pop_w),
    .done_o             (done_o),
    .accepted_o         (accepted_o),
    .slot_o             (slot_o),
    .tx_id_o            (tx_id_o),
    .tx_len_o           (tx_len_o),
    .tx_payload_o       (tx_payload_o),
    .rpm_o              (rpm_o),
    .current_tenths_o   (current_tenths_o),
    .duty_thousandths_o (duty_thousandths_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("item did not complete in three cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 3))
    else $error("result without a started item");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !accepted_o) |-> (tx_len_o == 4'd0 && tx_id_o == 10'd0 &&
                                 rpm_o == 32'sd0 && slot_o == 3'd0))
    else $error("rejected item carries nonzero fields");

  a_cmd_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && tx_len_o != 4'd0) |-> (rpm_o == 32'sd0 && current_tenths_o == 16'sd0 &&
                                      duty_thousandths_o == 16'sd0))
    else $error("command result carries status fields");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned NumPhases   = 6;

  typedef struct packed {
    mccs_pkg::func_e    func;
    logic [28:0]        rx_frame_id;
    logic [63:0]        rx_payload;
    logic [7:0]         target;
    logic signed [31:0] command_value;
    logic signed [17:0] fraction;
  } cmd_item_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         slot;
    logic [9:0]         tx_id;
    logic [3:0]         tx_len;
    logic [31:0]        tx_payload;
    logic signed [31:0] rpm;
    logic signed [15:0] current_tenths;
    logic signed [15:0] duty_thousandths;
  } frame_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         func_i = '0;
  logic [28:0]        rx_frame_id_i = '0;
  logic [63:0]        rx_payload_i = '0;
  logic [7:0]         target_i = '0;
  logic signed [31:0] command_value_i = '0;
  logic signed [17:0] fraction_i = '0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [19:0]        cfg_wdata_i = '0;
  logic               done_o;
  logic               accepted_o;
  logic [2:0]         slot_o;
  logic [9:0]         tx_id_o;
  logic [3:0]         tx_len_o;
  logic [31:0]        tx_payload_o;
  logic signed [31:0] rpm_o;
  logic signed [15:0] current_tenths_o;
  logic signed [15:0] duty_thousandths_o;

  motor_ctrl_can_command_status_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .func_i             (func_i),
    .rx_frame_id_i      (rx_frame_id_i),
    .rx_payload_i       (rx_payload_i),
    .target_i           (target_i),
    .command_value_i    (command_value_i),
    .fraction_i         (fraction_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .accepted_o         (accepted_o),
    .slot_o             (slot_o),
    .tx_id_o            (tx_id_o),
    .tx_len_o           (tx_len_o),
    .tx_payload_o       (tx_payload_o),
    .rpm_o              (rpm_o),
    .current_tenths_o   (current_tenths_o),
    .duty_thousandths_o (duty_thousandths_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state: shadow status table and limits
  logic [63:0] status_table [mccs_pkg::NumCtrl];
  logic [19:0] current_limit_q = mccs_pkg::CurrentLimitRst;
  logic [16:0] duty_limit_q    = mccs_pkg::DutyLimitRst;

  cmd_item_t     pending_items[$];
  frame_result_t expected_frames[$];
  cmd_item_t     cur_item;
  int unsigned   gap_left = 0;
  int unsigned   burst_left = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   mismatch_count = 0;

  initial begin
    for (int i = 0; i < mccs_pkg::NumCtrl; i++) status_table[i] = '0;
  end

  function automatic bit id_valid(logic [7:0] id);
    return id >= 8'd1 && id <= 8'(mccs_pkg::NumCtrl);
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // duty limit saturates at one
  function automatic longint duty_clamp_limit();
    longint lim;
    lim = (duty_limit_q > mccs_pkg::DutyOne) ? mccs_pkg::DutyOne : duty_limit_q;
    return lim;
  endfunction

  function automatic frame_result_t status_of(logic [7:0] id);
    frame_result_t r;
    logic [63:0]   e;
    r = '0;
    e = status_table[3'(id - 8'd1)];
    r.accepted         = 1'b1;
    r.slot             = 3'(id - 8'd1);
    r.rpm              = e[63:32];
    r.current_tenths   = e[31:16];
    r.duty_thousandths = e[15:0];
    return r;
  endfunction

  function automatic frame_result_t predict_frame(cmd_item_t it);
    frame_result_t r;
    longint        cmd;
    longint        frac;
    longint        ilim;
    longint        dlim;
    longint        val;
    mccs_pkg::pkt_e pkt;
    r    = '0;
    cmd  = $signed(it.command_value);
    frac = $signed(it.fraction);
    ilim = current_limit_q;
    dlim = duty_clamp_limit();
    val  = cmd;
    pkt  = mccs_pkg::PKT_RPM;
    case (it.func)
      mccs_pkg::FUNC_RX: begin
        if (it.rx_frame_id[15:8] == mccs_pkg::PktStatus &&
            id_valid(it.rx_frame_id[7:0])) begin
          status_table[3'(it.rx_frame_id[7:0] - 8'd1)] = it.rx_payload;
          r = status_of(it.rx_frame_id[7:0]);
        end
      end
      mccs_pkg::FUNC_READ: begin
        if (id_valid(it.target)) r = status_of(it.target);
      end
      mccs_pkg::FUNC_CURRENT: begin
        pkt = mccs_pkg::PKT_CURRENT;
        val = clamp_sym(cmd, ilim);
      end
      mccs_pkg::FUNC_CUR_PCT: begin
        pkt = mccs_pkg::PKT_CURRENT;
        val = clamp_sym((frac * ilim) / 65536, ilim);
      end
      mccs_pkg::FUNC_BRAKE: begin
        pkt = mccs_pkg::PKT_BRAKE;
        val = clamp_sym(cmd, ilim);
      end
      mccs_pkg::FUNC_DUTY: begin
        pkt = mccs_pkg::PKT_DUTY;
        val = clamp_sym(cmd, dlim);
      end
      mccs_pkg::FUNC_DUTY_PCT: begin
        pkt = mccs_pkg::PKT_DUTY;
        val = clamp_sym((frac * dlim) / 65536, dlim);
      end
      default: begin
        pkt = mccs_pkg::PKT_RPM;
        val = cmd;
      end
    endcase
    if (it.func != mccs_pkg::FUNC_RX && it.func != mccs_pkg::FUNC_READ &&
        id_valid(it.target)) begin
      r.accepted   = 1'b1;
      r.slot       = 3'(it.target - 8'd1);
      r.tx_id      = {pkt, it.target};
      r.tx_len     = 4'd4;
      r.tx_payload = val[31:0];
    end
    return r;
  endfunction

  // random item; mostly well-formed frames and valid targets, values near the limits
  function automatic cmd_item_t rand_item();
    cmd_item_t   it;
    int unsigned roll;
    longint      lim;
    longint      v;
    it.func          = mccs_pkg::func_e'($urandom_range(0, 7));
    it.rx_frame_id   = 29'($urandom);
    it.rx_payload    = {$urandom, $urandom};
    it.target        = 8'($urandom);
    it.command_value = $urandom;
    it.fraction      = 18'($urandom);
    roll = $urandom_range(0, 99);
    if (it.func == mccs_pkg::FUNC_RX) begin
      if (roll < 80)
        it.rx_frame_id[15:0] = {mccs_pkg::PktStatus,
                                8'($urandom_range(1, mccs_pkg::NumCtrl))};
      else if (roll < 90)
        it.rx_frame_id[15:8] = mccs_pkg::PktStatus;
    end else if (roll < 85) begin
      it.target = 8'($urandom_range(1, mccs_pkg::NumCtrl));
    end
    lim = (it.func == mccs_pkg::FUNC_DUTY || it.func == mccs_pkg::FUNC_DUTY_PCT)
          ? duty_clamp_limit() : longint'(current_limit_q);
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      v = longint'($urandom_range(0, 32'(2 * lim + 2))) - lim - 1;
      it.command_value = 32'(v);
    end else if (roll < 6) begin
      case ($urandom_range(0, 5))
        0: v = lim;
        1: v = lim + 1;
        2: v = -lim;
        3: v = -lim - 1;
        4: v = 64'sd2147483647;
        default: v = -64'sd2147483648;
      endcase
      it.command_value = 32'(v);
    end
    return it;
  endfunction

  task automatic push_item(input mccs_pkg::func_e f, input logic [28:0] fid,
                           input logic [63:0] pl, input logic [7:0] tgt,
                           input logic signed [31:0] cv, input logic signed [17:0] fr);
    cmd_item_t it;
    it.func          = f;
    it.rx_frame_id   = fid;
    it.rx_payload    = pl;
    it.target        = tgt;
    it.command_value = cv;
    it.fraction      = fr;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(input mccs_pkg::reg_idx_e idx, input logic [19:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx == mccs_pkg::REG_CURRENT_LIMIT) current_limit_q = data;
    else duty_limit_q = data[16:0];
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || start_i || expected_frames.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input frame_result_t want,
                               input frame_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t mismatch, %s", $realtime, what);
      $display("  expected acc=%0b slot=%0d id=%h len=%0d pl=%h rpm=%0d cur=%0d duty=%0d",
               want.accepted, want.slot, want.tx_id, want.tx_len, want.tx_payload,
               $signed(want.rpm), $signed(want.current_tenths),
               $signed(want.duty_thousandths));
      $display("  actual   acc=%0b slot=%0d id=%h len=%0d pl=%h rpm=%0d cur=%0d duty=%0d",
               got.accepted, got.slot, got.tx_id, got.tx_len, got.tx_payload,
               $signed(got.rpm), $signed(got.current_tenths),
               $signed(got.duty_thousandths));
    end
  endtask

  // driver: one item on the ports at a time, random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin : driver
    int unsigned roll;
    if (!rst_ni) begin
      start_i    <= 1'b0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      if (start_i && !busy_o) expected_frames.push_back(predict_frame(cur_item));
      if (start_i && busy_o) begin
        // hold the item until taken
      end else if (gap_left != 0) begin
        start_i  <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        func_i          <= cur_item.func;
        rx_frame_id_i   <= cur_item.rx_frame_id;
        rx_payload_i    <= cur_item.rx_payload;
        target_i        <= cur_item.target;
        command_value_i <= cur_item.command_value;
        fraction_i      <= cur_item.fraction;
        start_i         <= 1'b1;
        roll = $urandom_range(0, 99);
        if (burst_left != 0) begin
          burst_left <= burst_left - 1;
          gap_left   <= 0;
        end else if (roll < 3) begin
          burst_left <= $urandom_range(20, 60);
          gap_left   <= 0;
        end else if (roll < 50) begin
          gap_left <= 0;
        end else if (roll < 92) begin
          gap_left <= $urandom_range(1, 3);
        end else begin
          gap_left <= $urandom_range(8, 40);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin : monitor
    frame_result_t got;
    frame_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        got.accepted         = accepted_o;
        got.slot             = slot_o;
        got.tx_id            = tx_id_o;
        got.tx_len           = tx_len_o;
        got.tx_payload       = tx_payload_o;
        got.rpm              = rpm_o;
        got.current_tenths   = current_tenths_o;
        got.duty_thousandths = duty_thousandths_o;
        if (expected_frames.size() == 0) begin
          flag_mismatch("result with no item pending", '0, got);
        end else begin
          want = expected_frames.pop_front();
          if (got !== want) flag_mismatch("wrong result fields", want, got);
        end
      end
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("motor_ctrl_can_command_status_unit test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [19:0] cur_cfg;
    logic [19:0] duty_cfg;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // table is clear after reset
    push_item(mccs_pkg::FUNC_READ, '0, '0, 8'd1, '0, '0);
    push_item(mccs_pkg::FUNC_READ, '0, '0, 8'd8, '0, '0);
    // store and read back, upper id bits ignored
    push_item(mccs_pkg::FUNC_RX, {13'd0, mccs_pkg::PktStatus, 8'd1},
              {$urandom, $urandom}, '0, '0, '0);
    push_item(mccs_pkg::FUNC_READ, '0, '0, 8'd1, '0, '0);
    push_item(mccs_pkg::FUNC_RX, {13'h1FFF, mccs_pkg::PktStatus, 8'd8}, '1, 8'hFF, '1, '1);
    push_item(mccs_pkg::FUNC_READ, '0, '0, 8'd8, '0, '0);
    // bad ids and wrong packet code store nothing
    push_item(mccs_pkg::FUNC_RX, {13'd0, mccs_pkg::PktStatus, 8'd0}, '1, '0, '0, '0);
    push_item(mccs_pkg::FUNC_RX, {13'd0, mccs_pkg::PktStatus, 8'd9}, '1, '0, '0, '0);
    push_item(mccs_pkg::FUNC_RX, {13'd0, 8'd8, 8'd3}, '1, '0, '0, '0);
    push_item(mccs_pkg::FUNC_READ, '0, '0, 8'd3, '0, '0);
    // commands at the field extremes
    push_item(mccs_pkg::FUNC_CURRENT, '0, '0, 8'd2, 32'sh7FFFFFFF, '0);
    push_item(mccs_pkg::FUNC_CURRENT, '0, '0, 8'd2, 32'sh80000000, '0);
    push_item(mccs_pkg::FUNC_CURRENT, '0, '0, 8'd1, 32'sd1234, '0);
    push_item(mccs_pkg::FUNC_CUR_PCT, '0, '0, 8'd4, '0, 18'sh1FFFF);
    push_item(mccs_pkg::FUNC_CUR_PCT, '0, '0, 8'd4, '0, 18'sh20000);
    // small negative fraction truncates to zero
    push_item(mccs_pkg::FUNC_CUR_PCT, '0, '0, 8'd5, '0, -18'sd1);
    push_item(mccs_pkg::FUNC_BRAKE, '0, '0, 8'd6, -32'sd5000, '0);
    push_item(mccs_pkg::FUNC_BRAKE, '0, '0, 8'd6, 32'sd100000, '0);
    push_item(mccs_pkg::FUNC_DUTY, '0, '0, 8'd7, 32'sh7FFFFFFF, '0);
    push_item(mccs_pkg::FUNC_DUTY, '0, '0, 8'd7, 32'sh80000000, '0);
    push_item(mccs_pkg::FUNC_DUTY_PCT, '0, '0, 8'd8, '0, 18'sh1FFFF);
    push_item(mccs_pkg::FUNC_DUTY_PCT, '0, '0, 8'd8, '0, -18'sd3);
    push_item(mccs_pkg::FUNC_RPM, '0, '0, 8'd1, 32'sh7FFFFFFF, '0);
    push_item(mccs_pkg::FUNC_RPM, '0, '0, 8'd8, 32'sh80000000, '0);
    push_item(mccs_pkg::FUNC_CURRENT, '0, '0, 8'd0, 32'sd100, '0);
    push_item(mccs_pkg::FUNC_DUTY, '0, '0, 8'd255, 32'sd100, '0);
    push_item(mccs_pkg::FUNC_READ, '0, '0, 8'd9, '0, '0);

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase != 0) begin
        case (phase)
          1: begin
            cur_cfg  = 20'd0;
            duty_cfg = 20'd0;
          end
          2: begin
            cur_cfg  = 20'd1000000;
            duty_cfg = 20'd100000;
          end
          3: begin
            // duty limit above one saturates
            cur_cfg  = 20'($urandom_range(1, 1000000));
            duty_cfg = 20'h1FFFF;
          end
          4: begin
            cur_cfg  = 20'($urandom_range(1, 1000000));
            duty_cfg = 20'($urandom_range(0, 100000));
          end
          default: begin
            cur_cfg  = 20'($urandom_range(1, 2000));
            duty_cfg = 20'($urandom_range(100001, 131071));
          end
        endcase
        wait_drained();
        write_reg(mccs_pkg::REG_CURRENT_LIMIT, cur_cfg);
        write_reg(mccs_pkg::REG_DUTY_LIMIT, duty_cfg);
        cfg_we_i <= 1'b0;
      end
      repeat (PhaseItems) pending_items.push_back(rand_item());
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("motor_ctrl_can_command_status_unit test passed");
    end else begin
      $display("motor_ctrl_can_command_status_unit test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mccs_pkg.sv
rtl/mccs_front.sv
rtl/mccs_fifo.sv
rtl/mccs_back.sv
rtl/motor_ctrl_can_command_status_unit.sv
bench/tb_top.sv
